// ===== rtl/vcmi_pkg.sv =====
// shared types, constants and cube tables for the voxel cube mesh indexer
package vcmi_pkg;

  localparam int ID_W      = 13;
  localparam int CRD_W     = 4;
  localparam int CNR_W     = 5;
  localparam int EXT_W     = 5;
  localparam int EPOCH_W   = 2;
  localparam int IDX_W     = 6;
  localparam int N_CORNERS = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = 6'd35;
  localparam logic [EXT_W-1:0] EXT_RESET = 5'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2'd2;

  typedef logic [ID_W-1:0]    vid_t;
  typedef logic [2:0]         corner_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  // one map entry: present flag, epoch mark it was written in, vertex id
  typedef struct packed {
    logic   present;
    epoch_t epoch;
    vid_t   id;
  } map_ent_t;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] z;
  } voxel_t;

  // resolved corner of the current voxel
  typedef struct packed {
    vid_t id;
    logic fresh;
  } corner_ent_t;

  typedef struct packed {
    logic [N_CORNERS-1:0]        valid;
    corner_ent_t [N_CORNERS-1:0] ent;
  } corner_file_t;

  // corner slot used by each of the 36 triangle indices
  function automatic corner_t cube_corner(input logic [IDX_W-1:0] i);
    corner_t c;
    c = 3'd0;
    unique case (i)
      6'd6, 6'd11, 6'd18, 6'd23, 6'd34:         c = 3'd0;
      6'd7, 6'd16, 6'd30, 6'd35:                c = 3'd1;
      6'd8, 6'd9, 6'd12, 6'd17, 6'd24, 6'd29:   c = 3'd2;
      6'd10, 6'd22, 6'd25:                      c = 3'd3;
      6'd0, 6'd5, 6'd19, 6'd32, 6'd33:          c = 3'd4;
      6'd1, 6'd14, 6'd15, 6'd31:                c = 3'd5;
      6'd2, 6'd3, 6'd13, 6'd28:                 c = 3'd6;
      6'd4, 6'd20, 6'd21, 6'd26, 6'd27:         c = 3'd7;
      default:                                  c = 3'd0;
    endcase
    return c;
  endfunction

  // true where a slot shows up for the first time in the index list
  function automatic logic first_use(input logic [IDX_W-1:0] i);
    logic f;
    f = 1'b0;
    unique case (i)
      6'd0, 6'd1, 6'd2, 6'd4, 6'd6, 6'd7, 6'd8, 6'd10: f = 1'b1;
      default:                                         f = 1'b0;
    endcase
    return f;
  endfunction

  // grid offset of a slot: bit0 dx, bit1 dy, bit2 dz
  function automatic corner_t corner_off(input corner_t s);
    corner_t o;
    o = 3'd0;
    unique case (s)
      3'd0: o = 3'd0;
      3'd1: o = 3'd1;
      3'd2: o = 3'd3;
      3'd3: o = 3'd2;
      3'd4: o = 3'd4;
      3'd5: o = 3'd5;
      3'd6: o = 3'd7;
      3'd7: o = 3'd6;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/vcmi_map.sv =====
// corner map memory: one write port, one read port with registered data
module vcmi_map #(
  parameter int MAX_EXTENT = 16
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [$clog2((MAX_EXTENT+1)*(MAX_EXTENT+1)*(MAX_EXTENT+1))-1:0] wr_addr,
  input  vcmi_pkg::map_ent_t  wr_data,
  input  logic                rd_en,
  input  logic [$clog2((MAX_EXTENT+1)*(MAX_EXTENT+1)*(MAX_EXTENT+1))-1:0] rd_addr,
  output vcmi_pkg::map_ent_t  rd_data
);
  import vcmi_pkg::*;

  localparam int SIDE  = MAX_EXTENT + 1;
  localparam int DEPTH = SIDE * SIDE * SIDE;

  map_ent_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/vcmi_resolve.sv =====
// corner resolver: looks up the 8 corners of a voxel and assigns new vertex ids
module vcmi_resolve #(
  parameter int MAX_EXTENT = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    launch,
  input  logic                    clr_count,
  input  vcmi_pkg::voxel_t        voxel,
  input  vcmi_pkg::epoch_t        epoch,
  output logic                    rd_en,
  output logic [$clog2((MAX_EXTENT+1)*(MAX_EXTENT+1)*(MAX_EXTENT+1))-1:0] rd_addr,
  input  vcmi_pkg::map_ent_t      rd_data,
  output logic                    wr_en,
  output logic [$clog2((MAX_EXTENT+1)*(MAX_EXTENT+1)*(MAX_EXTENT+1))-1:0] wr_addr,
  output vcmi_pkg::map_ent_t      wr_data,
  output vcmi_pkg::corner_file_t  cfile
);
  import vcmi_pkg::*;

  localparam int SIDE   = MAX_EXTENT + 1;
  localparam int ADDR_W = $clog2(SIDE * SIDE * SIDE);

  logic                 issuing;
  logic [2:0]           k;
  logic                 p_valid;
  corner_t              p_slot;
  logic [ADDR_W-1:0]    p_addr;
  vid_t                 vcount;
  logic [N_CORNERS-1:0] cvalid;
  corner_ent_t [N_CORNERS-1:0] cent;

  corner_t          slot_k;
  corner_t          off;
  logic [CNR_W-1:0] cx;
  logic [CNR_W-1:0] cy;
  logic [CNR_W-1:0] cz;
  logic             hit;

  // slots are looked up in first-use order 4,5,6,7,0,1,2,3
  always_comb begin
    slot_k  = k ^ 3'b100;
    off     = corner_off(slot_k);
    cx      = CNR_W'(voxel.x) + CNR_W'(off[0]);
    cy      = CNR_W'(voxel.y) + CNR_W'(off[1]);
    cz      = CNR_W'(voxel.z) + CNR_W'(off[2]);
    rd_en   = issuing;
    rd_addr = ADDR_W'(cx) + ADDR_W'(cy) * ADDR_W'(SIDE) + ADDR_W'(cz) * ADDR_W'(SIDE * SIDE);
  end

  // entry counts only if written under the current epoch
  assign hit     = rd_data.present && (rd_data.epoch == epoch);
  assign wr_en   = p_valid && !hit;
  assign wr_addr = p_addr;
  assign wr_data = '{present: 1'b1, epoch: epoch, id: vcount};
  assign cfile   = '{valid: cvalid, ent: cent};

  // lookup issue and response tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      k       <= 3'd0;
      p_valid <= 1'b0;
      cvalid  <= '0;
      vcount  <= '0;
    end else begin
      p_valid <= issuing;
      if (launch) begin
        issuing <= 1'b1;
        k       <= 3'd0;
        cvalid  <= '0;
      end else if (issuing) begin
        k <= k + 3'd1;
        if (k == 3'd7) begin
          issuing <= 1'b0;
        end
      end
      if (p_valid) begin
        cvalid[p_slot] <= 1'b1;
      end
      if (clr_count) begin
        vcount <= '0;
      end else if (p_valid && !hit) begin
        vcount <= vcount + vid_t'(1);
      end
    end
  end

  // lookup payload and corner file contents
  always_ff @(posedge clk) begin
    p_slot <= slot_k;
    p_addr <= rd_addr;
    if (p_valid) begin
      cent[p_slot] <= hit ? corner_ent_t'{id: rd_data.id, fresh: 1'b0}
                          : corner_ent_t'{id: vcount, fresh: 1'b1};
    end
  end

endmodule

// ===== rtl/vcmi_emit.sv =====
// index emitter: walks the 36 cube indices, one result beat per cycle once resolved
module vcmi_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          launch,
  input  vcmi_pkg::voxel_t              voxel,
  input  vcmi_pkg::corner_file_t        cfile,
  output logic                          fin,
  output logic                          result_strobe,
  output logic [vcmi_pkg::ID_W-1:0]     vertex_index,
  output logic                          is_new_vertex,
  output logic [vcmi_pkg::CNR_W-1:0]    corner_x,
  output logic [vcmi_pkg::CNR_W-1:0]    corner_y,
  output logic [vcmi_pkg::CNR_W-1:0]    corner_z,
  output logic                          last_of_voxel
);
  import vcmi_pkg::*;

  logic             active;
  logic [IDX_W-1:0] step;
  corner_t          slot;
  corner_t          off;
  logic             fire;

  // step waits until its corner has been resolved
  always_comb begin
    slot = cube_corner(step);
    off  = corner_off(slot);
    fire = active && cfile.valid[slot];
    fin  = fire && (step == LAST_IDX);
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      step          <= '0;
      result_strobe <= 1'b0;
      last_of_voxel <= 1'b0;
    end else begin
      result_strobe <= fire;
      last_of_voxel <= fin;
      if (launch) begin
        active <= 1'b1;
        step   <= '0;
      end else if (fire) begin
        step <= step + IDX_W'(1);
        if (step == LAST_IDX) begin
          active <= 1'b0;
        end
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (fire) begin
      vertex_index  <= cfile.ent[slot].id;
      is_new_vertex <= cfile.ent[slot].fresh && first_use(step);
      corner_x      <= CNR_W'(voxel.x) + CNR_W'(off[0]);
      corner_y      <= CNR_W'(voxel.y) + CNR_W'(off[1]);
      corner_z      <= CNR_W'(voxel.z) + CNR_W'(off[2]);
    end
  end

endmodule

// ===== rtl/voxel_cube_mesh_indexer.sv =====
// top level of the voxel cube mesh indexer: control, configuration and map clearing
//
// One voxel is taken when start is high while busy is low. An occupied voxel inside
// the extents keeps busy high until its run ends and delivers 36 result beats, one per
// cycle; the next voxel can be taken in the cycle that shows the last beat. The
// lead-in before the first beat is the map read latency: the 8 corners go through the
// single read port of the map memory while ids are assigned, and the beats follow as
// corners resolve. Empty or out-of-range voxels leave busy low. The map is cleared by
// epoch marks; a full clearing pass over all (MAX_EXTENT+1)^3 map entries runs after
// reset and on every fourth start_mesh, during which busy is high. Results cannot be
// held off by the receiver.
module voxel_cube_mesh_indexer #(
  parameter int MAX_EXTENT = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              start_mesh,
  input  logic [vcmi_pkg::CRD_W-1:0]        voxel_x,
  input  logic [vcmi_pkg::CRD_W-1:0]        voxel_y,
  input  logic [vcmi_pkg::CRD_W-1:0]        voxel_z,
  input  logic                              occupied,
  input  logic                              cfg_wr,
  input  logic [vcmi_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [vcmi_pkg::EXT_W-1:0]        cfg_wdata,
  output logic                              result_strobe,
  output logic [vcmi_pkg::ID_W-1:0]         vertex_index,
  output logic                              is_new_vertex,
  output logic [vcmi_pkg::CNR_W-1:0]        corner_x,
  output logic [vcmi_pkg::CNR_W-1:0]        corner_y,
  output logic [vcmi_pkg::CNR_W-1:0]        corner_z,
  output logic                              last_of_voxel
);
  import vcmi_pkg::*;

  localparam int SIDE   = MAX_EXTENT + 1;
  localparam int DEPTH  = SIDE * SIDE * SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [5:0]        MAX_EXT_L = 6'(MAX_EXTENT);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  state_t            state;
  logic [EXT_W-1:0]  extent_x;
  logic [EXT_W-1:0]  extent_y;
  logic [EXT_W-1:0]  extent_z;
  epoch_t            epoch;
  logic [ADDR_W-1:0] clr_addr;
  logic              pend;
  logic              launch;
  voxel_t            voxel;

  logic              accept;
  logic              handled;
  logic              clr_count;
  logic              fin;

  logic              map_wr_en;
  logic [ADDR_W-1:0] map_wr_addr;
  map_ent_t          map_wr_data;
  logic              map_rd_en;
  logic [ADDR_W-1:0] map_rd_addr;
  map_ent_t          map_rd_data;
  logic              res_wr_en;
  logic [ADDR_W-1:0] res_wr_addr;
  map_ent_t          res_wr_data;
  corner_file_t      cfile;

  // input beat acceptance and range check
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign clr_count = accept && start_mesh;
  assign handled   = occupied
                   && ({1'b0, voxel_x} < extent_x)
                   && ({1'b0, voxel_y} < extent_y)
                   && ({1'b0, voxel_z} < extent_z)
                   && ({2'b00, voxel_x} < MAX_EXT_L)
                   && ({2'b00, voxel_y} < MAX_EXT_L)
                   && ({2'b00, voxel_z} < MAX_EXT_L);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      extent_x <= EXT_RESET;
      extent_y <= EXT_RESET;
      extent_z <= EXT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        REG_EXTENT_X: extent_x <= cfg_wdata;
        REG_EXTENT_Y: extent_y <= cfg_wdata;
        REG_EXTENT_Z: extent_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      epoch    <= '0;
      clr_addr <= '0;
      pend     <= 1'b0;
      launch   <= 1'b0;
    end else begin
      launch <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (start_mesh) begin
              epoch <= epoch + epoch_t'(1);
            end
            if (start_mesh && (epoch == '1)) begin
              state    <= ST_CLEAR;
              clr_addr <= '0;
              pend     <= handled;
            end else if (handled) begin
              state  <= ST_RUN;
              launch <= 1'b1;
            end
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            pend <= 1'b0;
            if (pend) begin
              state  <= ST_RUN;
              launch <= 1'b1;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_RUN: begin
          if (fin) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // voxel held for the whole run
  always_ff @(posedge clk) begin
    if (accept) begin
      voxel <= '{x: voxel_x, y: voxel_y, z: voxel_z};
    end
  end

  // map write port shared by the clearing pass and the resolver
  always_comb begin
    if (state == ST_CLEAR) begin
      map_wr_en   = 1'b1;
      map_wr_addr = clr_addr;
      map_wr_data = '0;
    end else begin
      map_wr_en   = res_wr_en;
      map_wr_addr = res_wr_addr;
      map_wr_data = res_wr_data;
    end
  end

  vcmi_map #(
    .MAX_EXTENT (MAX_EXTENT)
  ) u_map (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data)
  );

  vcmi_resolve #(
    .MAX_EXTENT (MAX_EXTENT)
  ) u_resolve (
    .clk       (clk),
    .rst       (rst),
    .launch    (launch),
    .clr_count (clr_count),
    .voxel     (voxel),
    .epoch     (epoch),
    .rd_en     (map_rd_en),
    .rd_addr   (map_rd_addr),
    .rd_data   (map_rd_data),
    .wr_en     (res_wr_en),
    .wr_addr   (res_wr_addr),
    .wr_data   (res_wr_data),
    .cfile     (cfile)
  );

  vcmi_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .launch        (launch),
    .voxel         (voxel),
    .cfile         (cfile),
    .fin           (fin),
    .result_strobe (result_strobe),
    .vertex_index  (vertex_index),
    .is_new_vertex (is_new_vertex),
    .corner_x      (corner_x),
    .corner_y      (corner_y),
    .corner_z      (corner_z),
    .last_of_voxel (last_of_voxel)
  );

  // corners of one voxel are distinct, so a lookup never meets its own write
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (map_wr_en && map_rd_en) |-> (map_wr_addr != map_rd_addr))
    else $error("map read and write hit the same entry");

  // no result beats while the map is being cleared
  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !result_strobe)
    else $error("result beat during clearing pass");

  // idle block leaves the map untouched
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !map_wr_en)
    else $error("map written while idle");

  // the closing beat of a voxel ends the run
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    fin |=> (last_of_voxel && result_strobe && !busy))
    else $error("last beat not aligned with end of run");

endmodule

// ===== dv/tb.sv =====
// testbench for the voxel cube mesh indexer: directed and random voxel scans checked beat by beat
module tb;
  import vcmi_pkg::*;

  localparam int GRID = 17;
  localparam int GRID_PTS = GRID * GRID * GRID;
  localparam int BEATS_PER_CUBE = 36;
  localparam int DRAIN_CYCLES = 45;

  // one expected result beat
  typedef struct {
    logic [ID_W-1:0]  id;
    logic             fresh;
    logic [CNR_W-1:0] cx;
    logic [CNR_W-1:0] cy;
    logic [CNR_W-1:0] cz;
    logic             last;
  } beat_t;

  // triangle list as corner slots, and slot to grid offset (bit0 dx, bit1 dy, bit2 dz)
  localparam logic [0:35][2:0] TRI_SLOT = {
    3'd4, 3'd5, 3'd6, 3'd6, 3'd7, 3'd4, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd0,
    3'd2, 3'd6, 3'd5, 3'd5, 3'd1, 3'd2, 3'd0, 3'd4, 3'd7, 3'd7, 3'd3, 3'd0,
    3'd2, 3'd3, 3'd7, 3'd7, 3'd6, 3'd2, 3'd1, 3'd5, 3'd4, 3'd4, 3'd0, 3'd1
  };
  localparam logic [0:7][2:0] SLOT_OFF = {
    3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              start_mesh = 1'b0;
  logic [CRD_W-1:0]  voxel_x = '0;
  logic [CRD_W-1:0]  voxel_y = '0;
  logic [CRD_W-1:0]  voxel_z = '0;
  logic              occupied = 1'b0;
  logic              cfg_wr = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = REG_EXTENT_X;
  logic [EXT_W-1:0]  cfg_wdata = '0;
  logic              result_strobe;
  logic [ID_W-1:0]   vertex_index;
  logic              is_new_vertex;
  logic [CNR_W-1:0]  corner_x;
  logic [CNR_W-1:0]  corner_y;
  logic [CNR_W-1:0]  corner_z;
  logic              last_of_voxel;

  // predictor state: vertex map (bit 13 present, low bits id), next id, extents
  logic [13:0]       vertex_map [GRID_PTS];
  logic [ID_W-1:0]   next_vid;
  logic [EXT_W-1:0]  ext_x;
  logic [EXT_W-1:0]  ext_y;
  logic [EXT_W-1:0]  ext_z;

  beat_t pending_beats [$];
  int    errors = 0;
  int    meshed_voxels = 0;
  bit    steady = 1'b0;

  voxel_cube_mesh_indexer u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .start_mesh    (start_mesh),
    .voxel_x       (voxel_x),
    .voxel_y       (voxel_y),
    .voxel_z       (voxel_z),
    .occupied      (occupied),
    .cfg_wr        (cfg_wr),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .result_strobe (result_strobe),
    .vertex_index  (vertex_index),
    .is_new_vertex (is_new_vertex),
    .corner_x      (corner_x),
    .corner_y      (corner_y),
    .corner_z      (corner_z),
    .last_of_voxel (last_of_voxel)
  );

  always #6 clk = ~clk;

  // forget every vertex and restart ids at zero
  function automatic void clear_vertex_map();
    for (int a = 0; a < GRID_PTS; a++) vertex_map[a] = '0;
    next_vid = '0;
  endfunction

  // expected beats of one voxel, queued in order; returns how many
  function automatic int mesh_voxel(input logic sm, input logic [CRD_W-1:0] vx, vy, vz,
                                    input logic occ);
    int         addr;
    logic [2:0] off;
    beat_t      b;
    if (sm) clear_vertex_map();
    if (!occ || {1'b0, vx} >= ext_x || {1'b0, vy} >= ext_y || {1'b0, vz} >= ext_z)
      return 0;
    for (int i = 0; i < BEATS_PER_CUBE; i++) begin
      off  = SLOT_OFF[TRI_SLOT[i]];
      b.cx = {1'b0, vx} + CNR_W'(off[0]);
      b.cy = {1'b0, vy} + CNR_W'(off[1]);
      b.cz = {1'b0, vz} + CNR_W'(off[2]);
      addr = int'(b.cx) + GRID * (int'(b.cy) + GRID * int'(b.cz));
      if (vertex_map[addr][13]) begin
        b.id    = vertex_map[addr][ID_W-1:0];
        b.fresh = 1'b0;
      end else begin
        b.id    = next_vid;
        b.fresh = 1'b1;
        vertex_map[addr] = {1'b1, next_vid};
        next_vid = next_vid + ID_W'(1);
      end
      b.last = (i == BEATS_PER_CUBE - 1);
      pending_beats.insert(pending_beats.size(), b);
    end
    return BEATS_PER_CUBE;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : beat_check
    beat_t e;
    if (!rst && result_strobe) begin
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual id %0d", $time, vertex_index);
        errors++;
      end else begin
        e = pending_beats.pop_front();
        check_field("vertex_index", 16'(e.id), 16'(vertex_index));
        check_field("is_new_vertex", 16'(e.fresh), 16'(is_new_vertex));
        check_field("corner_x", 16'(e.cx), 16'(corner_x));
        check_field("corner_y", 16'(e.cy), 16'(corner_y));
        check_field("corner_z", 16'(e.cz), 16'(corner_z));
        check_field("last_of_voxel", 16'(e.last), 16'(last_of_voxel));
      end
    end
  end

  // present one voxel and wait for the beat that takes it; start stays high afterwards
  task automatic send_voxel(input logic sm, input logic [CRD_W-1:0] vx, vy, vz,
                            input logic occ);
    if (!steady && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    start_mesh <= sm;
    voxel_x    <= vx;
    voxel_y    <= vy;
    voxel_z    <= vz;
    occupied   <= occ;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (mesh_voxel(sm, vx, vy, vz, occ) != 0) meshed_voxels++;
  endtask

  // hold off until every expected beat is in and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_extents(input logic [EXT_W-1:0] ex, ey, ez);
    cfg_wr    <= 1'b1;
    cfg_addr  <= REG_EXTENT_X;
    cfg_wdata <= ex;
    @(posedge clk);
    cfg_addr  <= REG_EXTENT_Y;
    cfg_wdata <= ey;
    @(posedge clk);
    cfg_addr  <= REG_EXTENT_Z;
    cfg_wdata <= ez;
    @(posedge clk);
    cfg_wr <= 1'b0;
    ext_x = ex;
    ext_y = ey;
    ext_z = ez;
  endtask

  // highest origin coordinate that still lands inside an extent
  function automatic int coord_span(input logic [EXT_W-1:0] e);
    if (e == 0) return 0;
    return (e > 16) ? 15 : int'(e) - 1;
  endfunction

  // reset extents: shared corners, repeats, far corner, clear on empty voxel
  task automatic test_directed_cubes();
    send_voxel(1'b1, 4'd0, 4'd0, 4'd0, 1'b1);
    send_voxel(1'b0, 4'd0, 4'd0, 4'd1, 1'b1);
    send_voxel(1'b0, 4'd0, 4'd0, 4'd0, 1'b1);
    send_voxel(1'b0, 4'd15, 4'd15, 4'd15, 1'b1);
    send_voxel(1'b0, 4'd5, 4'd9, 4'd3, 1'b0);
    send_voxel(1'b1, 4'd2, 4'd2, 4'd2, 1'b0);
    send_voxel(1'b0, 4'd2, 4'd2, 4'd2, 1'b1);
    send_voxel(1'b0, 4'd1, 4'd2, 4'd2, 1'b1);
  endtask

  // smallest, zero and oversized extents
  task automatic test_extent_limits();
    settle();
    set_extents(5'd1, 5'd1, 5'd1);
    send_voxel(1'b1, 4'd1, 4'd0, 4'd0, 1'b1);
    send_voxel(1'b0, 4'd0, 4'd1, 4'd0, 1'b1);
    send_voxel(1'b0, 4'd0, 4'd0, 4'd1, 1'b1);
    send_voxel(1'b0, 4'd0, 4'd0, 4'd0, 1'b1);
    settle();
    set_extents(5'd0, 5'd16, 5'd16);
    send_voxel(1'b0, 4'd0, 4'd0, 4'd0, 1'b1);
    send_voxel(1'b0, 4'd15, 4'd0, 4'd0, 1'b1);
    settle();
    set_extents(5'd16, 5'd0, 5'd0);
    send_voxel(1'b0, 4'd3, 4'd0, 4'd0, 1'b1);
    settle();
    set_extents(5'd31, 5'd31, 5'd31);
    send_voxel(1'b0, 4'd15, 4'd15, 4'd15, 1'b1);
    send_voxel(1'b0, 4'd14, 4'd15, 4'd15, 1'b1);
    settle();
    set_extents(5'd16, 5'd1, 5'd16);
    send_voxel(1'b0, 4'd3, 4'd0, 4'd7, 1'b1);
    send_voxel(1'b0, 4'd3, 4'd1, 4'd7, 1'b1);
  endtask

  // mostly small scanned boxes (x outer, z inner) with random fill, some noise voxels
  task automatic random_scans(input int target);
    int stop_at;
    int x0, y0, z0, nx, ny, nz;
    int x, y, z;
    logic sm;
    stop_at = meshed_voxels + target;
    while (meshed_voxels < stop_at) begin
      if ($urandom_range(99) < 80) begin
        x0 = $urandom_range(0, coord_span(ext_x));
        y0 = $urandom_range(0, coord_span(ext_y));
        z0 = $urandom_range(0, coord_span(ext_z));
        nx = $urandom_range(1, 3);
        ny = $urandom_range(1, 3);
        nz = $urandom_range(1, 3);
        sm = ($urandom_range(99) < 25);
        for (x = x0; x < x0 + nx && x < 16; x++)
          for (y = y0; y < y0 + ny && y < 16; y++)
            for (z = z0; z < z0 + nz && z < 16; z++) begin
              send_voxel(sm, x[3:0], y[3:0], z[3:0], $urandom_range(99) < 70);
              sm = 1'b0;
            end
      end else begin
        send_voxel($urandom_range(99) < 10, CRD_W'($urandom_range(15)),
                   CRD_W'($urandom_range(15)), CRD_W'($urandom_range(15)),
                   1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_full_chunk_steady();
    settle();
    set_extents(5'd16, 5'd16, 5'd16);
    steady = 1'b1;
    random_scans(15);
    steady = 1'b0;
  endtask

  task automatic test_random_extents();
    settle();
    set_extents(EXT_W'($urandom_range(1, 16)), EXT_W'($urandom_range(1, 16)),
                EXT_W'($urandom_range(1, 16)));
    random_scans(8);
    // pause the sender until the block has drained, then carry on unchanged
    settle();
    random_scans(8);
  endtask

  task automatic test_wide_extents();
    settle();
    set_extents(5'd31, EXT_W'($urandom_range(1, 31)), 5'd16);
    random_scans(15);
  endtask

  initial begin
    clear_vertex_map();
    ext_x = EXT_RESET;
    ext_y = EXT_RESET;
    ext_z = EXT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cubes();
    test_extent_limits();
    test_full_chunk_steady();
    test_random_extents();
    test_wide_extents();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // run limit
  initial begin
    #6000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vcmi_pkg.sv
rtl/vcmi_map.sv
rtl/vcmi_resolve.sv
rtl/vcmi_emit.sv
rtl/voxel_cube_mesh_indexer.sv
dv/tb.sv
